@@ hdl/glb_container_validator_defines.svh @@
// Assertion helpers used by the checker file.
`ifndef GLB_CONTAINER_VALIDATOR_DEFINES_SVH
`define GLB_CONTAINER_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define GCV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define GCV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/glbcv_pkg.sv @@
// ----------------------------------------------------------------------------
// glbcv_pkg
// Constants and status codes for the GLB container validator.
// ----------------------------------------------------------------------------
package glbcv_pkg;

  typedef logic [3:0] status_t;

  localparam status_t ST_OK          = 4'd0;
  localparam status_t ST_SHORT_HDR   = 4'd1;
  localparam status_t ST_BAD_MAGIC   = 4'd2;
  localparam status_t ST_BAD_VERSION = 4'd3;
  localparam status_t ST_BAD_LENGTH  = 4'd4;
  localparam status_t ST_CHDR_OOB    = 4'd5;
  localparam status_t ST_MISALIGNED  = 4'd6;
  localparam status_t ST_DATA_OOB    = 4'd7;
  localparam status_t ST_JSON_FIRST  = 4'd8;
  localparam status_t ST_DUP_JSON    = 4'd9;
  localparam status_t ST_DUP_BIN     = 4'd10;
  localparam status_t ST_NO_JSON     = 4'd11;

  localparam logic [31:0] GLB_MAGIC   = 32'h4654_6C67;
  localparam logic [31:0] GLB_VERSION = 32'd2;
  localparam logic [31:0] TYPE_JSON   = 32'h4E4F_534A;
  localparam logic [31:0] TYPE_BIN    = 32'h004E_4942;

  localparam int unsigned GLB_HEADER   = 12;
  localparam int unsigned CHUNK_HEADER = 8;
  localparam int unsigned LEN_LAST     = 3;   // last byte of chunk length word
  localparam int unsigned KIND_LAST    = 7;   // last byte of chunk type word
  localparam int unsigned MAGIC_LAST   = 3;
  localparam int unsigned VERSION_LAST = 7;
  localparam int unsigned DECL_LAST    = 11;
  localparam int unsigned VERSION_OFF  = 4;
  localparam int unsigned LENGTH_OFF   = 8;

endpackage

@@ hdl/glb_container_validator.sv @@
// ----------------------------------------------------------------------------
// glb_container_validator
// Framing check of a GLB container streamed one byte per item.
// ----------------------------------------------------------------------------
// Input channel: byte_valid/byte_ready carry data_byte and last_byte; one byte
// of the buffer per item, last_byte set on the final byte.
// Output channel: result_valid/result_ready carry one result per buffer, with
// status, error_offset, total_length and the JSON/BIN data ranges.
// Each byte is processed in the cycle it is accepted: header words are shifted
// in little-endian, chunk headers are closed and checked on their type byte.
// The result is registered and shows in the cycle after the final byte is
// accepted. Throughput: one byte per cycle while byte_ready is high, set by
// the chunk walk update (one add and compare against the declared length).
// A stalled result holds the output register; bytes keep being accepted while
// the result register is empty or being taken in the same cycle.
// Reset clears the walk state (next chunk at offset 12) and drops any result.
// After the final byte the walk state returns to its reset values.
// ----------------------------------------------------------------------------
module glb_container_validator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_ready,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   result_valid,
  input  logic                   result_ready,
  output glbcv_pkg::status_t     status,
  output logic [31:0]            error_offset,
  output logic [31:0]            total_length,
  output logic [31:0]            json_offset,
  output logic [31:0]            json_length,
  output logic                   bin_present,
  output logic [31:0]            bin_offset,
  output logic [31:0]            bin_length
);
  import glbcv_pkg::*;

  // walk state
  logic [32:0] byte_count, byte_count_next;
  logic [31:0] word_shift, word_shift_next;
  logic        magic_ok, magic_ok_next;
  logic        version_ok, version_ok_next;
  logic [31:0] declared_len, declared_len_next;
  logic [32:0] chunk_start, chunk_start_next;
  logic [31:0] chunk_len, chunk_len_next;
  logic        seen_json, seen_json_next;
  logic        seen_bin, seen_bin_next;
  logic        is_first_chunk, is_first_chunk_next;
  status_t     pending_error, pending_error_next;
  logic [31:0] pending_offset, pending_offset_next;
  logic [31:0] json_off, json_off_next, json_len, json_len_next;
  logic [31:0] bin_off, bin_off_next, bin_len, bin_len_next;

  logic        accept;
  logic        in_walk, hdr_oob, at_len, at_kind;
  logic [33:0] payload_start, data_end;
  status_t     close_err, res_status;
  logic [31:0] res_eoff;
  logic        short_hdr;

  assign accept     = byte_valid && byte_ready;
  assign byte_ready = !result_valid || result_ready;

  assign payload_start = {1'b0, chunk_start} + 34'(CHUNK_HEADER);
  assign data_end   = payload_start + {2'b0, chunk_len};
  assign in_walk    = (byte_count >= 33'(GLB_HEADER)) &&
                      (byte_count < {1'b0, declared_len}) &&
                      (pending_error == ST_OK);
  assign hdr_oob    = in_walk && (byte_count == chunk_start) &&
                      (payload_start > {2'b0, declared_len});
  assign at_len     = {1'b0, byte_count} == ({1'b0, chunk_start} + 34'(LEN_LAST));
  assign at_kind    = {1'b0, byte_count} == ({1'b0, chunk_start} + 34'(KIND_LAST));

  // checks done when the chunk type word is complete
  always_comb begin
    priority if (chunk_len[1:0] != 2'b00) begin
      close_err = ST_MISALIGNED;
    end else if (data_end > {2'b0, declared_len}) begin
      close_err = ST_DATA_OOB;
    end else if (word_shift_next == TYPE_JSON) begin
      close_err = !is_first_chunk ? ST_JSON_FIRST :
                  seen_json       ? ST_DUP_JSON   : ST_OK;
    end else if (word_shift_next == TYPE_BIN) begin
      close_err = is_first_chunk ? ST_JSON_FIRST :
                  seen_bin       ? ST_DUP_BIN    : ST_OK;
    end else begin
      close_err = is_first_chunk ? ST_JSON_FIRST : ST_OK;
    end
  end

  always_comb begin
    byte_count_next     = (byte_count == '1) ? byte_count : byte_count + 33'd1;
    word_shift_next     = {data_byte, word_shift[31:8]};
    magic_ok_next       = magic_ok;
    version_ok_next     = version_ok;
    declared_len_next   = declared_len;
    chunk_start_next    = chunk_start;
    chunk_len_next      = chunk_len;
    seen_json_next      = seen_json;
    seen_bin_next       = seen_bin;
    is_first_chunk_next = is_first_chunk;
    pending_error_next  = pending_error;
    pending_offset_next = pending_offset;
    json_off_next       = json_off;
    json_len_next       = json_len;
    bin_off_next        = bin_off;
    bin_len_next        = bin_len;

    if (byte_count == 33'(MAGIC_LAST)) begin
      magic_ok_next = (word_shift_next == GLB_MAGIC);
    end else if (byte_count == 33'(VERSION_LAST)) begin
      version_ok_next = (word_shift_next == GLB_VERSION);
    end else if (byte_count == 33'(DECL_LAST)) begin
      declared_len_next = word_shift_next;
    end

    if (hdr_oob) begin
      pending_error_next  = ST_CHDR_OOB;
      pending_offset_next = chunk_start[31:0];
    end else if (in_walk && at_len) begin
      chunk_len_next = word_shift_next;
    end else if (in_walk && at_kind) begin
      if (close_err != ST_OK) begin
        pending_error_next  = close_err;
        pending_offset_next = chunk_start[31:0];
      end else begin
        if (word_shift_next == TYPE_JSON) begin
          seen_json_next = 1'b1;
          json_off_next  = payload_start[31:0];
          json_len_next  = chunk_len;
        end else if (word_shift_next == TYPE_BIN) begin
          seen_bin_next = 1'b1;
          bin_off_next  = payload_start[31:0];
          bin_len_next  = chunk_len;
        end
        chunk_start_next    = data_end[32:0];
        is_first_chunk_next = 1'b0;
      end
    end
  end

  // final status in check order
  assign short_hdr = byte_count_next < 33'(GLB_HEADER);

  always_comb begin
    res_eoff = '0;
    priority if (short_hdr) begin
      res_status = ST_SHORT_HDR;
    end else if (!magic_ok_next) begin
      res_status = ST_BAD_MAGIC;
    end else if (!version_ok_next) begin
      res_status = ST_BAD_VERSION;
      res_eoff   = 32'(VERSION_OFF);
    end else if ((declared_len_next < 32'(GLB_HEADER)) ||
                 ({1'b0, declared_len_next} > byte_count_next)) begin
      res_status = ST_BAD_LENGTH;
      res_eoff   = 32'(LENGTH_OFF);
    end else if (pending_error_next != ST_OK) begin
      res_status = pending_error_next;
      res_eoff   = pending_offset_next;
    end else if (!seen_json_next) begin
      res_status = ST_NO_JSON;
    end else begin
      res_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      word_shift     <= '0;
      magic_ok       <= 1'b0;
      version_ok     <= 1'b0;
      declared_len   <= '0;
      chunk_start    <= 33'(GLB_HEADER);
      chunk_len      <= '0;
      seen_json      <= 1'b0;
      seen_bin       <= 1'b0;
      is_first_chunk <= 1'b1;
      pending_error  <= ST_OK;
      pending_offset <= '0;
      json_off       <= '0;
      json_len       <= '0;
      bin_off        <= '0;
      bin_len        <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count     <= '0;
        word_shift     <= '0;
        magic_ok       <= 1'b0;
        version_ok     <= 1'b0;
        declared_len   <= '0;
        chunk_start    <= 33'(GLB_HEADER);
        chunk_len      <= '0;
        seen_json      <= 1'b0;
        seen_bin       <= 1'b0;
        is_first_chunk <= 1'b1;
        pending_error  <= ST_OK;
        pending_offset <= '0;
        json_off       <= '0;
        json_len       <= '0;
        bin_off        <= '0;
        bin_len        <= '0;
      end else begin
        byte_count     <= byte_count_next;
        word_shift     <= word_shift_next;
        magic_ok       <= magic_ok_next;
        version_ok     <= version_ok_next;
        declared_len   <= declared_len_next;
        chunk_start    <= chunk_start_next;
        chunk_len      <= chunk_len_next;
        seen_json      <= seen_json_next;
        seen_bin       <= seen_bin_next;
        is_first_chunk <= is_first_chunk_next;
        pending_error  <= pending_error_next;
        pending_offset <= pending_offset_next;
        json_off       <= json_off_next;
        json_len       <= json_len_next;
        bin_off        <= bin_off_next;
        bin_len        <= bin_len_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      status       <= res_status;
      error_offset <= res_eoff;
      total_length <= short_hdr ? '0 : declared_len_next;
      if (res_status == ST_OK) begin
        json_offset <= json_off_next;
        json_length <= json_len_next;
        bin_present <= seen_bin_next;
        bin_offset  <= bin_off_next;
        bin_length  <= bin_len_next;
      end else begin
        json_offset <= '0;
        json_length <= '0;
        bin_present <= 1'b0;
        bin_offset  <= '0;
        bin_length  <= '0;
      end
    end
  end

endmodule

@@ hdl/glbcv_checker.sv @@
// ----------------------------------------------------------------------------
// glbcv_checker
// Port-level checks on the result channel of the GLB container validator.
// ----------------------------------------------------------------------------
`include "glb_container_validator_defines.svh"

module glbcv_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_valid,
  input logic                   byte_ready,
  input logic                   last_byte,
  input logic                   result_valid,
  input logic                   result_ready,
  input glbcv_pkg::status_t     status,
  input logic [31:0]            error_offset,
  input logic [31:0]            total_length,
  input logic [31:0]            json_offset,
  input logic [31:0]            json_length,
  input logic                   bin_present,
  input logic [31:0]            bin_offset,
  input logic [31:0]            bin_length
);
  import glbcv_pkg::*;

  logic ok_res, zero_off, rng_clear, last_in;

  assign ok_res    = result_valid && (status == ST_OK);
  assign zero_off  = result_valid && ((status == ST_OK) || (status == ST_SHORT_HDR) ||
                     (status == ST_BAD_MAGIC) || (status == ST_NO_JSON));
  assign rng_clear = (json_offset == '0) && (json_length == '0) && !bin_present &&
                     (bin_offset == '0) && (bin_length == '0);
  assign last_in   = byte_valid && byte_ready && last_byte;

  // stalled result keeps valid, status, error offset and JSON offset
  `GCV_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready,
    result_valid && $stable(status) && $stable(error_offset) && $stable(json_offset),
    "result changed while stalled")

  `GCV_ASSERT_NOW(a_zero_off, clk, rst, zero_off, error_offset == '0,
    "nonzero error offset for a status without one")

  `GCV_ASSERT_NOW(a_err_ranges, clk, rst, result_valid && !ok_res, rng_clear,
    "ranges reported on a failed container")

  `GCV_ASSERT_NOW(a_short, clk, rst, result_valid && (status == ST_SHORT_HDR),
    total_length == '0, "total length reported on a short header")

  `GCV_ASSERT_NEXT(a_last, clk, rst, last_in, result_valid,
    "no result after the final byte of a buffer")

endmodule

bind glb_container_validator glbcv_checker u_glbcv_checker (.*);

@@ tb/tb_glb_container_validator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_glb_container_validator
// Streams GLB containers into the validator one byte per item, mostly
// well-formed files with random chunk layout and content, plus files with one
// injected framing fault and raw noise. A behavioral model of the chunk walk
// predicts each verdict, which is checked field by field against the DUT.
// ----------------------------------------------------------------------------
module tb_glb_container_validator;
  import glbcv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [32:0] COUNT_TOP   = '1;
  localparam int unsigned LONG_HOLD_AT = 600;

  typedef struct {
    status_t     status;
    logic [31:0] err_off;
    logic [31:0] total_len;
    logic [31:0] json_off;
    logic [31:0] json_len;
    logic        bin_pres;
    logic [31:0] bin_off;
    logic [31:0] bin_len;
  } verdict_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold_first;  // wait for all verdicts before sending
  } byte_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  status_t     status;
  logic [31:0] error_offset;
  logic [31:0] total_length;
  logic [31:0] json_offset;
  logic [31:0] json_length;
  logic        bin_present;
  logic [31:0] bin_offset;
  logic [31:0] bin_length;

  glb_container_validator u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .error_offset (error_offset),
    .total_length (total_length),
    .json_offset  (json_offset),
    .json_length  (json_length),
    .bin_present  (bin_present),
    .bin_offset   (bin_offset),
    .bin_length   (bin_length)
  );

  // stimulus and scoreboard
  byte_item_t  byte_stream[$];
  logic [7:0]  file_buf[$];
  verdict_t    pending_verdicts[$];
  int unsigned stream_total = 0;
  int unsigned bytes_accepted = 0;
  int unsigned quiet_from = 32'hFFFF_FFFF;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_left = 0;
  logic        long_hold_done = 1'b0;

  // walk state of the container model
  logic [32:0] pos_count;
  logic [31:0] hdr_word;
  logic        magic_good, version_good;
  logic [31:0] decl_len;
  logic [63:0] next_chunk;
  logic [31:0] chk_len, chk_kind;
  logic        got_json, got_bin, opening_chunk;
  status_t     held_status;
  logic [31:0] held_offset;
  logic [31:0] json_off_m, json_len_m, bin_off_m, bin_len_m;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void clear_walk();
    pos_count     = '0;
    hdr_word      = '0;
    magic_good    = 1'b0;
    version_good  = 1'b0;
    decl_len      = '0;
    next_chunk    = 64'(GLB_HEADER);
    chk_len       = '0;
    chk_kind      = '0;
    got_json      = 1'b0;
    got_bin       = 1'b0;
    opening_chunk = 1'b1;
    held_status   = ST_OK;
    held_offset   = '0;
    json_off_m    = '0;
    json_len_m    = '0;
    bin_off_m     = '0;
    bin_len_m     = '0;
  endfunction

  function automatic void raise_fault(input status_t code);
    held_status = code;
    held_offset = next_chunk[31:0];
  endfunction

  // Advances the container model by one byte; returns 1 with the verdict on
  // the final byte of a buffer.
  function automatic logic validate_byte(input logic [7:0] b, input logic last,
                                         output verdict_t v);
    logic [63:0] p, dstart, dend, size, decl64;
    logic        advance;
    p       = {31'd0, pos_count};
    advance = 1'b0;
    v       = '{default: '0};
    if (pos_count != COUNT_TOP) pos_count = pos_count + 33'd1;
    hdr_word = {b, hdr_word[31:8]};
    if (p == MAGIC_LAST) magic_good = (hdr_word == GLB_MAGIC);
    else if (p == VERSION_LAST) version_good = (hdr_word == GLB_VERSION);
    else if (p == DECL_LAST) decl_len = hdr_word;
    decl64 = {32'd0, decl_len};
    if (p >= GLB_HEADER && p < decl64 && held_status == ST_OK) begin
      if (p == next_chunk && next_chunk + CHUNK_HEADER > decl64) raise_fault(ST_CHDR_OOB);
      if (held_status == ST_OK) begin
        if (p == next_chunk + LEN_LAST) begin
          chk_len = hdr_word;
        end else if (p == next_chunk + KIND_LAST) begin
          chk_kind = hdr_word;
          dstart   = next_chunk + CHUNK_HEADER;
          dend     = dstart + {32'd0, chk_len};
          if (chk_len[1:0] != 2'b00) begin
            raise_fault(ST_MISALIGNED);
          end else if (dend > decl64) begin
            raise_fault(ST_DATA_OOB);
          end else if (chk_kind == TYPE_JSON) begin
            if (!opening_chunk) raise_fault(ST_JSON_FIRST);
            else if (got_json) raise_fault(ST_DUP_JSON);
            else begin
              got_json   = 1'b1;
              json_off_m = dstart[31:0];
              json_len_m = chk_len;
              advance    = 1'b1;
            end
          end else if (chk_kind == TYPE_BIN) begin
            if (opening_chunk) raise_fault(ST_JSON_FIRST);
            else if (got_bin) raise_fault(ST_DUP_BIN);
            else begin
              got_bin   = 1'b1;
              bin_off_m = dstart[31:0];
              bin_len_m = chk_len;
              advance   = 1'b1;
            end
          end else if (opening_chunk) begin
            raise_fault(ST_JSON_FIRST);
          end else begin
            advance = 1'b1;  // unknown chunk, skipped
          end
          if (advance) begin
            next_chunk    = dend;
            opening_chunk = 1'b0;
          end
        end
      end
    end
    if (!last) return 1'b0;

    size     = {31'd0, pos_count};
    v.status = ST_OK;
    if (size < GLB_HEADER) begin
      v.status = ST_SHORT_HDR;
    end else if (!magic_good) begin
      v.status = ST_BAD_MAGIC;
    end else if (!version_good) begin
      v.status  = ST_BAD_VERSION;
      v.err_off = VERSION_OFF;
    end else if (decl_len < GLB_HEADER || decl64 > size) begin
      v.status  = ST_BAD_LENGTH;
      v.err_off = LENGTH_OFF;
    end else if (held_status != ST_OK) begin
      v.status  = held_status;
      v.err_off = held_offset;
    end else if (!got_json) begin
      v.status = ST_NO_JSON;
    end
    v.total_len = (size < GLB_HEADER) ? 32'd0 : decl_len;
    if (v.status == ST_OK) begin
      v.json_off = json_off_m;
      v.json_len = json_len_m;
      v.bin_pres = got_bin;
      v.bin_off  = bin_off_m;
      v.bin_len  = bin_len_m;
    end
    clear_walk();
    return 1'b1;
  endfunction

  task automatic add_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_buf.insert(file_buf.size(), w[8*i +: 8]);
  endtask

  task automatic queue_file(input logic hold);
    byte_item_t item;
    for (int i = 0; i < file_buf.size(); i++) begin
      item.data       = file_buf[i];
      item.last       = (i == file_buf.size() - 1);
      item.hold_first = hold && (i == 0);
      byte_stream.insert(byte_stream.size(), item);
    end
  endtask

  // One container: clean most of the time, else one framing fault or noise.
  task automatic build_container();
    int          n_chunks, pad, trail, mode, fault, total, cut, pick, idx;
    logic [31:0] kinds[8];
    int          dlens[8];
    logic [31:0] lfields[8];
    logic [31:0] magic_w, version_w, decl_w;
    logic        bin_used;
    file_buf.delete();
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      if ($urandom_range(0, 1) == 0) add_word(GLB_MAGIC);
      repeat ($urandom_range(1, 30))
        file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
      return;
    end
    n_chunks = $urandom_range(1, 4);
    bin_used = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (i == 0) begin
        kinds[i] = TYPE_JSON;
      end else if ($urandom_range(0, 2) == 0 && !bin_used) begin
        kinds[i] = TYPE_BIN;
        bin_used = 1'b1;
      end else begin
        kinds[i] = $urandom();
        while (kinds[i] == TYPE_JSON || kinds[i] == TYPE_BIN) kinds[i] = $urandom();
      end
      dlens[i] = 4 * $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) dlens[i] = 4 * $urandom_range(4, 12);
      lfields[i] = dlens[i];
    end
    magic_w   = GLB_MAGIC;
    version_w = GLB_VERSION;
    pad       = 0;
    trail     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    fault     = (mode >= 60) ? $urandom_range(0, 14) : -1;
    pick      = $urandom_range(0, n_chunks - 1);
    case (fault)
      0: n_chunks = 0;
      1: kinds[0] = TYPE_BIN;
      2: kinds[0] = $urandom();
      3: begin
        kinds[n_chunks] = TYPE_JSON;
        n_chunks++;
      end
      4: begin
        kinds[n_chunks]     = TYPE_BIN;
        kinds[n_chunks + 1] = TYPE_BIN;
        n_chunks += 2;
      end
      5: lfields[pick] = lfields[pick] + $urandom_range(1, 3);
      6: lfields[pick] = ($urandom_range(0, 1) == 0) ? ($urandom() & ~32'd3)
                                                     : lfields[pick] + 4 * $urandom_range(1, 8);
      7: pad = $urandom_range(1, 7);
      8: magic_w = magic_w ^ (32'd1 << $urandom_range(0, 31));
      9: version_w = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom();
      default: ;
    endcase
    total = GLB_HEADER + pad;
    for (int i = 0; i < n_chunks; i++) total += CHUNK_HEADER + dlens[i];
    decl_w = total;
    if (fault == 10) decl_w = $urandom_range(0, 11);
    if (fault == 11) decl_w = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF
                                                           : total + $urandom_range(1, 16);
    add_word(magic_w);
    add_word(version_w);
    add_word(decl_w);
    for (int i = 0; i < n_chunks; i++) begin
      add_word(lfields[i]);
      add_word(kinds[i]);
      repeat (dlens[i]) file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
    end
    repeat (pad + trail) file_buf.insert(file_buf.size(), 8'($urandom_range(0, 255)));
    if (fault == 12 || fault == 14) begin
      cut = (fault == 14) ? $urandom_range(1, 11) : $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > cut) void'(file_buf.pop_back());
    end
    if (fault == 13) begin
      idx = $urandom_range(0, file_buf.size() - 1);
      file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // driver
  always @(posedge clk) begin
    verdict_t   v;
    byte_item_t item;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && byte_ready) begin
        if (validate_byte(data_byte, last_byte, v))
          pending_verdicts.insert(pending_verdicts.size(), v);
        bytes_accepted++;
      end
      if (!byte_valid || byte_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_valid <= 1'b0;
        end else if (byte_stream.size() == 0) begin
          byte_valid <= 1'b0;
        end else if (byte_stream[0].hold_first &&
                     (pending_verdicts.size() != 0 || result_valid)) begin
          byte_valid <= 1'b0;
        end else if (bytes_accepted < quiet_from && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 6);
          byte_valid <= 1'b0;
        end else begin
          item = byte_stream.pop_front();
          data_byte  <= item.data;
          last_byte  <= item.last;
          byte_valid <= 1'b1;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  // one long receiver stall so the result register fills and backs up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!long_hold_done && bytes_accepted >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      hold_left      <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor and result-side flow control
  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result, status %0d", status);
        end else begin
          want = pending_verdicts.pop_front();
          compare_field("status", {28'd0, want.status}, {28'd0, status});
          compare_field("error_offset", want.err_off, error_offset);
          compare_field("total_length", want.total_len, total_length);
          compare_field("json_offset", want.json_off, json_offset);
          compare_field("json_length", want.json_len, json_length);
          compare_field("bin_present", {31'd0, want.bin_pres}, {31'd0, bin_present});
          compare_field("bin_offset", want.bin_off, bin_offset);
          compare_field("bin_length", want.bin_len, bin_length);
        end
      end
      if (hold_left > 0) begin
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else if (bytes_accepted < quiet_from && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 6);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int files;
    clear_walk();
    // directed: one-byte buffers at both byte extremes, then the smallest
    // valid container (empty JSON chunk)
    file_buf.delete();
    file_buf.insert(file_buf.size(), 8'hFF);
    queue_file(1'b0);
    file_buf.delete();
    file_buf.insert(file_buf.size(), 8'h00);
    queue_file(1'b0);
    file_buf.delete();
    add_word(GLB_MAGIC);
    add_word(GLB_VERSION);
    add_word(GLB_HEADER + CHUNK_HEADER);
    add_word(32'd0);
    add_word(TYPE_JSON);
    queue_file(1'b0);
    files = 0;
    while (byte_stream.size() < 1450) begin
      build_container();
      queue_file(files == 10);
      files++;
    end
    stream_total = byte_stream.size();
    quiet_from   = stream_total - 150;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted != stream_total) @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/glbcv_pkg.sv
hdl/glb_container_validator.sv
hdl/glbcv_checker.sv
tb/tb_glb_container_validator.sv
